// ===== design/audio_rate_feedback_regulator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// audio rate feedback regulator assertion macros
// wraps concurrent assertions so they can be compiled out
// ----------------------------------------------------------------------------
`ifndef AUDIO_RATE_FEEDBACK_REGULATOR_UNIT_ASSERT_SVH
`define AUDIO_RATE_FEEDBACK_REGULATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ARFR_ASSERT_CLK(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) prop) \
    else $error("arfr assertion failed");

`define ARFR_ASSERT(lbl, prop) \
  `ARFR_ASSERT_CLK(lbl, clk, rst_n, prop)

`else

`define ARFR_ASSERT_CLK(lbl, ck, rstn, prop)

`define ARFR_ASSERT(lbl, prop)

`endif

`endif

// ===== design/arfr_pkg.sv =====
// ----------------------------------------------------------------------------
// arfr_pkg
// shared types and constants of the audio rate feedback regulator
// ----------------------------------------------------------------------------
package arfr_pkg;

  localparam int unsigned RING_BYTES   = 16384;

  localparam int unsigned NOMINAL_W    = 8;
  localparam int unsigned FILL_W       = 15;
  localparam int unsigned MAXCORR_W    = 16;
  localparam int unsigned INTERVAL_W   = 8;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned RATE_W       = 24;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned IN_DATA_W    = 48;
  localparam int unsigned OUT_DATA_W   = 24;

  localparam logic [NOMINAL_W-1:0]  NOMINAL_RST  = NOMINAL_W'(48);
  localparam logic [FILL_W-1:0]     TARGET_RST   = FILL_W'(RING_BYTES / 2);
  localparam logic [MAXCORR_W-1:0]  MAXCORR_RST  = MAXCORR_W'(32768);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(4);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NOMINAL  = 2'd0,
    REG_TARGET   = 2'd1,
    REG_MAXCORR  = 2'd2,
    REG_INTERVAL = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [NOMINAL_W-1:0]  nominal;
    logic [FILL_W-1:0]     target;
    logic [MAXCORR_W-1:0]  max_corr;
    logic [INTERVAL_W-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic              seeded;
    logic [TIME_W-1:0] last_ms;
    logic [FILL_W-1:0] average;
  } reg_state_t;

endpackage

// ===== design/arfr_core.sv =====
// ----------------------------------------------------------------------------
// arfr_core
// one poll: unseed, seed or update of fill average and clamped rate request
// ----------------------------------------------------------------------------
module arfr_core import arfr_pkg::*; (
  input  cfg_t              cfg,
  input  reg_state_t        cur,
  input  logic              streaming,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [FILL_W-1:0] fill_bytes,
  output reg_state_t        nxt,
  output logic              emit,
  output logic [RATE_W-1:0] rate
);

  logic [TIME_W-1:0]   elapsed;
  logic                due;
  logic signed [15:0]  err;
  logic signed [15:0]  step;
  logic signed [15:0]  avg_sum;
  logic [FILL_W-1:0]   avg_new;
  logic signed [16:0]  dif;
  logic signed [20:0]  delta;
  logic signed [20:0]  limit;
  logic signed [20:0]  corr;
  logic signed [24:0]  rate_sum;
  logic [RATE_W-1:0]   nominal_rate;

  assign nominal_rate = {cfg.nominal, 16'h0000};
  assign elapsed      = now_ms - cur.last_ms;
  assign due          = elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.interval};

  // exponential average, 1/8 weight, arithmetic shift
  assign err     = $signed({1'b0, fill_bytes}) - $signed({1'b0, cur.average});
  assign step    = err >>> 3;
  assign avg_sum = $signed({1'b0, cur.average}) + step;
  assign avg_new = avg_sum[FILL_W-1:0];

  assign dif   = $signed({2'b00, cfg.target}) - $signed({2'b00, avg_new});
  assign delta = {dif, 4'b0000};
  assign limit = $signed({5'b00000, cfg.max_corr});

  always_comb begin
    priority if (delta > limit) begin
      corr = limit;
    end else if (delta < -limit) begin
      corr = -limit;
    end else begin
      corr = delta;
    end
  end

  assign rate_sum = $signed({1'b0, nominal_rate}) + {{4{corr[20]}}, corr};

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    rate = nominal_rate;
    priority if (!streaming) begin
      nxt.seeded = 1'b0;
    end else if (!cur.seeded) begin
      nxt.seeded  = 1'b1;
      nxt.last_ms = now_ms;
      nxt.average = cfg.target;
      emit        = 1'b1;
    end else if (due) begin
      nxt.last_ms = now_ms;
      nxt.average = avg_new;
      emit        = 1'b1;
      rate        = rate_sum[24] ? '0 : rate_sum[RATE_W-1:0];
    end
  end

endmodule

// ===== design/audio_rate_feedback_regulator_unit.sv =====
// an accepted poll passes the input register, then the result register
// one poll per cycle unless the output stalls; average and timestamp update in one pass
// a poll with no result leaves the output side untouched
// reset (rst_n low, synchronous) clears handshake state, seeded flag, timestamp,
// average, and loads the register defaults
// ----------------------------------------------------------------------------
// audio_rate_feedback_regulator_unit
// asynchronous feedback rate regulator for an audio sink, 8.16 output
// ----------------------------------------------------------------------------
`include "audio_rate_feedback_regulator_unit_assert.svh"

module audio_rate_feedback_regulator_unit import arfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // now_ms[31:0], fill_bytes[46:32], zero pad
  input  logic                   in_tuser,   // streaming
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata   // feedback_rate[23:0]
);

  cfg_t              cfg_r;
  reg_state_t        st_r;
  reg_state_t        st_nxt;

  logic              s1_valid_r;
  logic              s1_streaming_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [FILL_W-1:0] s1_fill_r;

  logic              out_valid_r;
  logic [RATE_W-1:0] out_rate_r;

  logic              s1_fire;
  logic              in_fire;
  logic              emit;
  logic [RATE_W-1:0] rate;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nominal  <= NOMINAL_RST;
      cfg_r.target   <= TARGET_RST;
      cfg_r.max_corr <= MAXCORR_RST;
      cfg_r.interval <= INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_NOMINAL:  cfg_r.nominal  <= cfg_wdata[NOMINAL_W-1:0];
        REG_TARGET:   cfg_r.target   <= cfg_wdata[FILL_W-1:0];
        REG_MAXCORR:  cfg_r.max_corr <= cfg_wdata[MAXCORR_W-1:0];
        REG_INTERVAL: cfg_r.interval <= cfg_wdata[INTERVAL_W-1:0];
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_streaming_r <= in_tuser;
      s1_now_r       <= in_tdata[TIME_W-1:0];
      s1_fill_r      <= in_tdata[TIME_W+FILL_W-1:TIME_W];
    end
  end

  arfr_core u_core (
    .cfg        (cfg_r),
    .cur        (st_r),
    .streaming  (s1_streaming_r),
    .now_ms     (s1_now_r),
    .fill_bytes (s1_fill_r),
    .nxt        (st_nxt),
    .emit       (emit),
    .rate       (rate)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_rate_r <= rate;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rate_r;

  `ARFR_ASSERT(a_out_from_pass, $rose(out_valid_r) |-> $past(s1_fire))
  `ARFR_ASSERT(a_seed_drop, ($fell(st_r.seeded) && $past(rst_n)) |->
    $past(s1_fire && !s1_streaming_r))
  `ARFR_ASSERT(a_time_only_on_pass, (!$stable(st_r.last_ms) && $past(rst_n)) |-> $past(s1_fire))
  `ARFR_ASSERT(a_no_overrun, (out_valid_r && !out_tready) |-> !s1_fire)

endmodule
